[hdl/cap_pkg.sv]
package cap_pkg;

   localparam int FRAC_BITS     = 20;
   localparam int SCREEN_WIDTH  = 240;
   localparam int SCREEN_HEIGHT = 320;
   localparam int CORDIC_STEPS  = 20;
   localparam int NUM_REGS      = 8;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic signed [27:0] Q_PI      = 28'sd3294199;
   localparam logic signed [27:0] Q_HALF_PI = 28'sd1647099;
   localparam logic signed [27:0] Q_TWO_PI  = 28'sd6588397;
   localparam logic signed [23:0] CORDIC_K  = 24'sd636751;
   localparam logic signed [23:0] POS_INIT  = 24'sd104858;
   localparam logic signed [23:0] Q_MAX     = 24'sh7FFFFF;
   localparam logic signed [23:0] Q_MIN     = -24'sh800000;

   localparam logic [3:0] REG_START_A = 4'd0;
   localparam logic [3:0] REG_START_B = 4'd1;
   localparam logic [3:0] REG_START_C = 4'd2;
   localparam logic [3:0] REG_START_D = 4'd3;
   localparam logic [3:0] REG_DRIFT_A = 4'd4;
   localparam logic [3:0] REG_DRIFT_B = 4'd5;
   localparam logic [3:0] REG_DRIFT_C = 4'd6;
   localparam logic [3:0] REG_DRIFT_D = 4'd7;

   typedef struct packed {
      logic frame_start;
      logic restart;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   function automatic logic [19:0] atan_lookup(input logic [4:0] i);
      logic [19:0] v;
      case (i)
         5'd0:    v = 20'd823550;
         5'd1:    v = 20'd486170;
         5'd2:    v = 20'd256879;
         5'd3:    v = 20'd130396;
         5'd4:    v = 20'd65451;
         5'd5:    v = 20'd32757;
         5'd6:    v = 20'd16383;
         5'd7:    v = 20'd8192;
         5'd8:    v = 20'd4096;
         5'd9:    v = 20'd2048;
         5'd10:   v = 20'd1024;
         5'd11:   v = 20'd512;
         5'd12:   v = 20'd256;
         5'd13:   v = 20'd128;
         5'd14:   v = 20'd64;
         5'd15:   v = 20'd32;
         5'd16:   v = 20'd16;
         5'd17:   v = 20'd8;
         5'd18:   v = 20'd4;
         5'd19:   v = 20'd2;
         default: v = 20'd0;
      endcase
      return v;
   endfunction

endpackage

[hdl/cap_front.sv]
module cap_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  cap_pkg::item_type      in_item,
   input  logic                   pop,
   output cap_pkg::queue_out_type q_out
);

   cap_pkg::item_type mem_ff [cap_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, do_pop;

   assign in_ready    = (count_ff < 2'(cap_pkg::QUEUE_DEPTH));
   assign push        = in_valid && in_ready;
   assign do_pop      = pop && (count_ff != 2'd0);
   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

[hdl/cap_back.sv]
module cap_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [3:0]             csr_index,
   input  logic [22:0]            csr_data,
   input  cap_pkg::queue_out_type q_in,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [7:0]             out_px,
   output logic [8:0]             out_py,
   output logic [15:0]            out_color
);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_RED, S_FOLD, S_ROT, S_SAVE, S_COMB, S_PIX, S_OUT
   } state_type;

   state_type          state_ff;
   logic [22:0]        start_ff [4];
   logic [10:0]        drift_ff [4];
   logic signed [23:0] coef_ff [4];
   logic signed [23:0] pos_x_ff, pos_y_ff, nx_ff, ny_ff, sin_ff;
   logic signed [47:0] prod_ff;
   logic signed [23:0] ang_ff, cx_ff, cy_ff;
   logic               neg_cos_ff;
   logic [4:0]         step_ff;
   logic [1:0]         eval_ff;
   logic [7:0]         px_ff;
   logic [8:0]         py_ff;
   logic [15:0]        color_ff;
   logic               out_valid_ff;
   logic [7:0]         out_px_ff;
   logic [8:0]         out_py_ff;
   logic [15:0]        out_color_ff;

   logic signed [23:0] coef_in [4];
   logic signed [23:0] mul_a, mul_b, cos_v;
   logic signed [47:0] prod_in;
   logic signed [27:0] t, r_red, r_fold;
   logic [27:0]        mag;
   logic signed [27:0] sum;
   logic signed [23:0] sum_sat;
   logic signed [23:0] dx, dy, atan_v;
   logic signed [32:0] vx, vy;
   logic               on_x, on_y;
   logic [23:0]        ax, ay;
   logic [30:0]        cx120, cy120;
   logic [7:0]         red, green;
   logic               load_out;

   function automatic logic signed [24:0] Q_MAX_W();
      return 25'(cap_pkg::Q_MAX);
   endfunction

   function automatic logic signed [24:0] Q_MIN_W();
      return 25'(cap_pkg::Q_MIN);
   endfunction

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         logic signed [24:0] s;
         coef_in[k] = q_in.item.restart ? 24'(signed'(start_ff[k])) : coef_ff[k];
         s = 25'(coef_in[k]) + 25'(signed'(drift_ff[k]));
         if (q_in.item.frame_start) begin
            if (s > 25'(Q_MAX_W())) coef_in[k] = cap_pkg::Q_MAX;
            else if (s < 25'(Q_MIN_W())) coef_in[k] = cap_pkg::Q_MIN;
            else coef_in[k] = s[23:0];
         end
      end
   end

   // shared multiplier
   always_comb begin
      cos_v = neg_cos_ff ? -cx_ff : cx_ff;
      if (state_ff == S_SAVE) begin
         mul_a = eval_ff[1] ? coef_ff[3] : coef_ff[2];
         mul_b = cos_v;
      end else begin
         mul_a = eval_ff[1] ? coef_ff[1] : coef_ff[0];
         mul_b = (eval_ff == 2'd0 || eval_ff == 2'd3) ? pos_y_ff : pos_x_ff;
      end
      prod_in = 48'(mul_a) * 48'(mul_b);
   end

   // angle reduction into (-pi, pi]
   always_comb begin
      t   = prod_ff[47:20];
      mag = t[27] ? 28'(-t) : 28'(t);
      for (int k = 3; k >= 0; k--) begin
         if (mag >= 28'(cap_pkg::Q_TWO_PI <<< k)) begin
            mag = mag - 28'(cap_pkg::Q_TWO_PI <<< k);
         end
      end
      r_red = (t[27] && mag != 28'd0) ? cap_pkg::Q_TWO_PI - signed'(mag) : signed'(mag);
      if (r_red > cap_pkg::Q_PI) r_red = r_red - cap_pkg::Q_TWO_PI;
   end

   always_comb begin
      r_fold = 28'(ang_ff);
      if (r_fold > cap_pkg::Q_HALF_PI) r_fold = cap_pkg::Q_PI - r_fold;
      else if (r_fold < -cap_pkg::Q_HALF_PI) r_fold = -cap_pkg::Q_PI - r_fold;
   end

   always_comb begin
      dx     = cy_ff >>> step_ff;
      dy     = cx_ff >>> step_ff;
      atan_v = 24'(cap_pkg::atan_lookup(step_ff));
   end

   always_comb begin
      sum = 28'(sin_ff) + prod_ff[47:20];
      if (sum > 28'(cap_pkg::Q_MAX)) sum_sat = cap_pkg::Q_MAX;
      else if (sum < 28'(cap_pkg::Q_MIN)) sum_sat = cap_pkg::Q_MIN;
      else sum_sat = sum[23:0];
   end

   // screen mapping and color
   always_comb begin
      vx = (33'(cap_pkg::SCREEN_WIDTH / 2) <<< cap_pkg::FRAC_BITS) + 33'(nx_ff) * 33'sd70;
      vy = (33'(cap_pkg::SCREEN_HEIGHT / 2) <<< cap_pkg::FRAC_BITS) + 33'(ny_ff) * 33'sd90;
      on_x = vx[32] ? (vx > -(33'sd1 <<< cap_pkg::FRAC_BITS))
                    : (vx[32:20] < 13'(cap_pkg::SCREEN_WIDTH));
      on_y = vy[32] ? (vy > -(33'sd1 <<< cap_pkg::FRAC_BITS))
                    : (vy[32:20] < 13'(cap_pkg::SCREEN_HEIGHT));
      ax    = nx_ff[23] ? 24'(-nx_ff) : 24'(nx_ff);
      ay    = ny_ff[23] ? 24'(-ny_ff) : 24'(ny_ff);
      cx120 = 31'(ax) * 31'd120;
      cy120 = 31'(ay) * 31'd120;
      red   = cx120[27:20] + 8'd50;
      green = cy120[27:20] + 8'd50;
   end

   assign pop      = (state_ff == S_IDLE) && q_in.valid;
   assign load_out = (state_ff == S_OUT) && (!out_valid_ff || out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            start_ff[k] <= '0;
            drift_ff[k] <= '0;
         end
      end else if (csr_valid && csr_index <= cap_pkg::REG_DRIFT_D) begin
         if (!csr_index[2]) start_ff[csr_index[1:0]] <= csr_data;
         else drift_ff[csr_index[1:0]] <= csr_data[10:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) coef_ff[k] <= '0;
         pos_x_ff     <= cap_pkg::POS_INIT;
         pos_y_ff     <= cap_pkg::POS_INIT;
         eval_ff      <= 2'd0;
         step_ff      <= 5'd0;
      end else begin
         if (load_out) begin
            out_valid_ff <= 1'b1;
            out_px_ff    <= px_ff;
            out_py_ff    <= py_ff;
            out_color_ff <= color_ff;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_in.valid) begin
                  for (int k = 0; k < 4; k++) coef_ff[k] <= coef_in[k];
                  if (q_in.item.restart) begin
                     pos_x_ff <= cap_pkg::POS_INIT;
                     pos_y_ff <= cap_pkg::POS_INIT;
                  end
                  eval_ff  <= 2'd0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= S_RED;
            end
            S_RED: begin
               ang_ff   <= r_red[23:0];
               state_ff <= S_FOLD;
            end
            S_FOLD: begin
               ang_ff     <= r_fold[23:0];
               neg_cos_ff <= (28'(ang_ff) != r_fold);
               cx_ff      <= cap_pkg::CORDIC_K;
               cy_ff      <= '0;
               step_ff    <= 5'd0;
               state_ff   <= S_ROT;
            end
            S_ROT: begin
               if (!ang_ff[23]) begin
                  cx_ff  <= cx_ff - dx;
                  cy_ff  <= cy_ff + dy;
                  ang_ff <= ang_ff - atan_v;
               end else begin
                  cx_ff  <= cx_ff + dx;
                  cy_ff  <= cy_ff - dy;
                  ang_ff <= ang_ff + atan_v;
               end
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'(cap_pkg::CORDIC_STEPS - 1)) state_ff <= S_SAVE;
            end
            S_SAVE: begin
               if (!eval_ff[0]) begin
                  sin_ff   <= cy_ff;
                  eval_ff  <= eval_ff + 2'd1;
                  state_ff <= S_MUL;
               end else begin
                  prod_ff  <= prod_in;
                  state_ff <= S_COMB;
               end
            end
            S_COMB: begin
               if (eval_ff == 2'd1) nx_ff <= sum_sat;
               else ny_ff <= sum_sat;
               if (eval_ff == 2'd3) begin
                  state_ff <= S_PIX;
               end else begin
                  eval_ff  <= eval_ff + 2'd1;
                  state_ff <= S_MUL;
               end
            end
            S_PIX: begin
               pos_x_ff <= nx_ff;
               pos_y_ff <= ny_ff;
               px_ff    <= vx[32] ? 8'd0 : vx[27:20];
               py_ff    <= vy[32] ? 9'd0 : vy[28:20];
               color_ff <= {red[7:3], green[7:2], 5'd25};
               state_ff <= (on_x && on_y) ? S_OUT : S_IDLE;
            end
            S_OUT: begin
               if (load_out) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign out_valid = out_valid_ff;
   assign out_px    = out_px_ff;
   assign out_py    = out_py_ff;
   assign out_color = out_color_ff;

endmodule

[hdl/clifford_attractor_plotter.sv]
// clifford attractor point generator, signed q3.20
// req channel: one transaction per iteration; tdata bit 0 restart (reload
//   coefficients from csr, x = y = 0.1), bit 1 frame_start (add drift values)
// rsp channel: one transaction per on-screen point, none for off-screen
//   points; tdata carries pixel_x, pixel_y and an rgb565 color
// csr channel: index 0..3 start_a..start_d, 4..7 drift_a..drift_d, others
//   ignored; always ready, write only while the block is idle
// each item takes four sine/cosine evaluations, each a multiply, reduce,
//   fold and 20 cordic steps on one shared rotator, plus two combine
//   steps, the queue pop, the screen mapping and the output load; one
//   item is worked on at a time
// a two-entry queue takes req transactions while an item is in work
// rsp is held in an output register; while rsp_tready is low the next point
//   is computed and waits for the register to free up
// reset clears the queue, the registers, the coefficients and sets x, y to 0.1
module clifford_attractor_plotter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // restart, frame_start, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // pixel_x[7:0], pixel_y[16:8], pixel_color[32:17]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [22:0] csr_data
);

   cap_pkg::item_type      req_item;
   cap_pkg::queue_out_type q_out;
   logic                   pop;
   logic [7:0]             px;
   logic [8:0]             py;
   logic [15:0]            color;

   assign req_item.restart     = req_tdata[0];
   assign req_item.frame_start = req_tdata[1];
   assign csr_ready            = 1'b1;

   cap_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (req_item),
      .pop      (pop),
      .q_out    (q_out)
   );

   cap_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_in      (q_out),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_px    (px),
      .out_py    (py),
      .out_color (color)
   );

   assign rsp_tdata = {7'd0, color, py, px};

   a_reset_quiet: assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");
   a_px_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (px < 8'(cap_pkg::SCREEN_WIDTH)))
      else $error("pixel_x off screen");
   a_py_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (py < 9'(cap_pkg::SCREEN_HEIGHT)))
      else $error("pixel_y off screen");
   a_blue: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (color[4:0] == 5'd25))
      else $error("blue channel wrong");

endmodule

[tb/sv/tb_clifford_attractor_plotter.sv]
module tb_clifford_attractor_plotter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 400;
   localparam int DRIFT_FRAMES   = 120;
   localparam int RANDOM_ITEMS   = 284;

   typedef struct {
      logic [7:0]  px;
      logic [8:0]  py;
      logic [15:0] color;
   } pixel_type;

   typedef struct {
      logic restart;
      logic frame_start;
   } req_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;       // restart, frame_start, zero fill
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;            // pixel_x, pixel_y, pixel_color, zero fill
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [22:0] csr_data = '0;

   logic signed [22:0] start_reg [4];
   logic signed [10:0] drift_reg [4];
   longint    coef [4];
   longint    pos_x, pos_y;
   pixel_type pixel_q[$];
   int        errors = 0;
   int        quiet_cycles = 0;
   bit        idle_on = 1'b1;
   bit        finished = 1'b0;

   longint atan_c [cap_pkg::CORDIC_STEPS] = '{823550, 486170, 256879, 130396, 65451, 32757,
      16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

   req_row_type directed_rows [12] = '{
      '{1'b0, 1'b0}, '{1'b0, 1'b1}, '{1'b0, 1'b0}, '{1'b1, 1'b0}, '{1'b1, 1'b1},
      '{1'b0, 1'b1}, '{1'b0, 1'b1}, '{1'b0, 1'b0}, '{1'b1, 1'b0}, '{1'b0, 1'b0},
      '{1'b0, 1'b1}, '{1'b1, 1'b1}
   };

   clifford_attractor_plotter dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint sat_q(input longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function automatic longint trunc_q(input longint v);
      if (v >= 0) return v >>> cap_pkg::FRAC_BITS;
      return -((-v) >>> cap_pkg::FRAC_BITS);
   endfunction

   task automatic sin_cos(input longint t, output longint s, output longint c);
      longint r, cx, cy, dx, dy;
      bit     flip;
      r = t % longint'(cap_pkg::Q_TWO_PI);
      flip = 1'b0;
      cx = longint'(cap_pkg::CORDIC_K);
      cy = 0;
      if (r < 0) r += longint'(cap_pkg::Q_TWO_PI);
      if (r > longint'(cap_pkg::Q_PI)) r -= longint'(cap_pkg::Q_TWO_PI);
      if (r > longint'(cap_pkg::Q_HALF_PI)) begin
         r = longint'(cap_pkg::Q_PI) - r;
         flip = 1'b1;
      end else if (r < -longint'(cap_pkg::Q_HALF_PI)) begin
         r = -longint'(cap_pkg::Q_PI) - r;
         flip = 1'b1;
      end
      for (int i = 0; i < cap_pkg::CORDIC_STEPS; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (r >= 0) begin
            cx -= dx; cy += dy; r -= atan_c[i];
         end else begin
            cx += dx; cy -= dy; r += atan_c[i];
         end
      end
      s = cy;
      c = flip ? -cx : cx;
   endtask

   task automatic iterate_point(input logic restart, input logic frame_start);
      longint s1, c1, s2, c2, nx, ny, px, py, ax, ay, red, green;
      pixel_type p;
      if (restart) begin
         for (int i = 0; i < 4; i++) coef[i] = longint'(start_reg[i]);
         pos_x = longint'(cap_pkg::POS_INIT);
         pos_y = longint'(cap_pkg::POS_INIT);
      end
      if (frame_start)
         for (int i = 0; i < 4; i++) coef[i] = sat_q(coef[i] + longint'(drift_reg[i]));
      sin_cos((coef[0] * pos_y) >>> cap_pkg::FRAC_BITS, s1, c1);
      sin_cos((coef[0] * pos_x) >>> cap_pkg::FRAC_BITS, s2, c2);
      nx = s1 + ((coef[2] * c2) >>> cap_pkg::FRAC_BITS);
      sin_cos((coef[1] * pos_x) >>> cap_pkg::FRAC_BITS, s1, c1);
      sin_cos((coef[1] * pos_y) >>> cap_pkg::FRAC_BITS, s2, c2);
      ny = s1 + ((coef[3] * c2) >>> cap_pkg::FRAC_BITS);
      pos_x = sat_q(nx);
      pos_y = sat_q(ny);
      px = trunc_q((longint'(cap_pkg::SCREEN_WIDTH / 2) <<< cap_pkg::FRAC_BITS) + 70 * pos_x);
      py = trunc_q((longint'(cap_pkg::SCREEN_HEIGHT / 2) <<< cap_pkg::FRAC_BITS) + 90 * pos_y);
      if (px < 0 || px >= cap_pkg::SCREEN_WIDTH || py < 0 || py >= cap_pkg::SCREEN_HEIGHT)
         return;
      ax = pos_x < 0 ? -pos_x : pos_x;
      ay = pos_y < 0 ? -pos_y : pos_y;
      red = (((ax * 120) >>> cap_pkg::FRAC_BITS) + 50) & 255;
      green = (((ay * 120) >>> cap_pkg::FRAC_BITS) + 50) & 255;
      p.px = px[7:0];
      p.py = py[8:0];
      p.color = 16'(((red & 8'hF8) << 8) | ((green & 8'hFC) << 3) | (200 >> 3));
      pixel_q.push_back(p);
   endtask

   task automatic send_item(input logic restart, input logic frame_start);
      if (idle_on && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, frame_start, restart};
      do @(posedge clock); while (!req_tready);
      iterate_point(restart, frame_start);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [3:0] index, input logic [22:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (index < 4) start_reg[index[1:0]] = value;
      else if (index < cap_pkg::NUM_REGS) drift_reg[index[1:0]] = value[10:0];
   endtask

   task automatic csr_done();
      csr_valid <= 1'b0;
   endtask

   function automatic logic [22:0] pick_start();
      case ($urandom_range(4))
         0: return -23'sd2097152;
         1: return 23'sd2097152;
         2: return 23'($urandom);
         default: return 23'($urandom_range(4194304) - 2097152);
      endcase
   endfunction

   function automatic logic [22:0] pick_drift();
      case ($urandom_range(4))
         0: return 23'(-1024);
         1: return 23'd1023;
         2: return 23'($urandom);
         default: return 23'($urandom_range(2047) - 1024);
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !idle_on || $urandom_range(99) >= 22;
   end

   always @(posedge clock) begin
      pixel_type p;
      if (rsp_tvalid && rsp_tready) begin
         if (pixel_q.size() == 0) begin
            $display("%0t: unexpected rsp transaction, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            p = pixel_q.pop_front();
            if (rsp_tdata[7:0] !== p.px) begin
               $display("%0t: pixel_x expected %0d actual %0d", $time, p.px, rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tdata[16:8] !== p.py) begin
               $display("%0t: pixel_y expected %0d actual %0d", $time, p.py, rsp_tdata[16:8]);
               errors++;
            end
            if (rsp_tdata[32:17] !== p.color) begin
               $display("%0t: pixel_color expected %h actual %h", $time, p.color,
                        rsp_tdata[32:17]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT && !finished) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 4; i++) begin
         start_reg[i] = '0;
         drift_reg[i] = '0;
         coef[i] = 0;
      end
      pos_x = longint'(cap_pkg::POS_INIT);
      pos_y = longint'(cap_pkg::POS_INIT);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset state, then start values of +-2.0 with the drift field extremes
      foreach (directed_rows[i]) send_item(directed_rows[i].restart, directed_rows[i].frame_start);
      wait_idle();
      write_csr(cap_pkg::REG_START_A, 23'sd2097152);
      write_csr(cap_pkg::REG_START_B, -23'sd2097152);
      write_csr(cap_pkg::REG_START_C, 23'sd2097152);
      write_csr(cap_pkg::REG_START_D, -23'sd2097152);
      write_csr(cap_pkg::REG_DRIFT_A, 23'd1023);
      write_csr(cap_pkg::REG_DRIFT_B, 23'(-1024));
      write_csr(cap_pkg::REG_DRIFT_C, 23'(-1024));
      write_csr(cap_pkg::REG_DRIFT_D, 23'd1023);
      write_csr(4'd8, 23'h7FFFFF);
      write_csr(4'd15, 23'h2AAAAA);
      csr_done();
      foreach (directed_rows[i]) send_item(directed_rows[i].restart, directed_rows[i].frame_start);

      // largest coefficient bits drifting outward in both directions
      wait_idle();
      write_csr(cap_pkg::REG_START_A, 23'h3FFFFF);
      write_csr(cap_pkg::REG_START_B, 23'h400000);
      write_csr(cap_pkg::REG_START_C, 23'h3FFFFF);
      write_csr(cap_pkg::REG_START_D, 23'h400000);
      write_csr(cap_pkg::REG_DRIFT_A, 23'd1023);
      write_csr(cap_pkg::REG_DRIFT_B, 23'(-1024));
      write_csr(cap_pkg::REG_DRIFT_C, 23'd1023);
      write_csr(cap_pkg::REG_DRIFT_D, 23'(-1024));
      csr_done();
      send_item(1'b1, 1'b1);
      for (int n = 0; n < DRIFT_FRAMES; n++) send_item(1'b0, 1'b1);

      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         idle_on = (ph != 2);
         for (int r = 0; r < 8; r++)
            write_csr(4'(r), r < 4 ? pick_start() : pick_drift());
         if ($urandom_range(1)) write_csr(4'($urandom_range(15, 8)), 23'($urandom));
         csr_done();
         send_item(1'b1, 1'($urandom));
         for (int n = 0; n < RANDOM_ITEMS; n++)
            send_item($urandom_range(99) < 5, $urandom_range(99) < 30);
      end

      idle_on = 1'b1;
      wait_idle();
      finished = 1'b1;
      if (errors == 0 && pixel_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[files.f]
hdl/cap_pkg.sv
hdl/cap_front.sv
hdl/cap_back.sv
hdl/clifford_attractor_plotter.sv
tb/sv/tb_clifford_attractor_plotter.sv
